### sv/vpd_pkg.sv
package vpd_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned DIV_W      = 31;
    localparam int unsigned NUM_CELLS  = DATA_W;
    localparam int unsigned CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_DEPTH  = 2'd1;

    localparam logic [DIV_W-1:0]  NEAR_LIMIT_RST = 31'd50;
    localparam logic [DATA_W-1:0] MID_DEPTH_RST  = 32'd0;

    localparam logic signed [DATA_W-1:0] CLIP_MARK_X   = -32'sd5000;
    localparam logic signed [DATA_W-1:0] CLIP_ESCAPE_X = -32'sd5001;

    typedef struct packed {
        logic signed [DATA_W-1:0] depth;
        logic signed [DATA_W-1:0] x_num;
        logic signed [DATA_W-1:0] y_num;
        logic                     last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] screen_x;
        logic signed [DATA_W-1:0] screen_y;
        logic signed [DATA_W-1:0] screen_depth;
        logic                     last_out;
    } t_out_item;

    // state carried from cell to cell
    typedef struct packed {
        logic              clip;
        logic              last;
        logic              neg_x;
        logic              neg_y;
        logic [DIV_W-1:0]  divisor;
        logic [DIV_W-1:0]  rem_x;
        logic [DATA_W-1:0] quo_x;
        logic [DIV_W-1:0]  rem_y;
        logic [DATA_W-1:0] quo_y;
        logic [DATA_W-1:0] depth_out;
    } t_cell_data;

endpackage

### sv/vpd_cell.sv
module vpd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  vpd_pkg::t_cell_data i_data,
    output logic                o_valid,
    output vpd_pkg::t_cell_data o_data
);
    import vpd_pkg::*;

    logic                r_valid;
    t_cell_data          r_data;
    t_cell_data          n_data;
    logic [DATA_W-1:0]   shift_x;
    logic [DATA_W-1:0]   shift_y;
    logic [DATA_W-1:0]   dvs;
    logic                bit_x;
    logic                bit_y;

    // one restoring step per numerator: bring down the next dividend bit
    always_comb begin
        dvs     = {1'b0, i_data.divisor};
        shift_x = {i_data.rem_x, i_data.quo_x[DATA_W-1]};
        shift_y = {i_data.rem_y, i_data.quo_y[DATA_W-1]};
        bit_x   = (shift_x >= dvs);
        bit_y   = (shift_y >= dvs);
        n_data  = i_data;
        n_data.rem_x = bit_x ? DIV_W'(shift_x - dvs) : shift_x[DIV_W-1:0];
        n_data.rem_y = bit_y ? DIV_W'(shift_y - dvs) : shift_y[DIV_W-1:0];
        n_data.quo_x = {i_data.quo_x[DATA_W-2:0], bit_x};
        n_data.quo_y = {i_data.quo_y[DATA_W-2:0], bit_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/vpd_out_stage.sv
module vpd_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  vpd_pkg::t_cell_data i_data,
    output logic                o_advance,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vpd_pkg::t_out_item  o_out_item
);
    import vpd_pkg::*;

    logic              r_out_valid;
    t_out_item         r_out;
    logic              r_skid_valid;
    t_out_item         r_skid;
    t_out_item         n_item;
    logic [DATA_W-1:0] q_x;
    logic [DATA_W-1:0] q_y;
    logic              arrive;

    // restore signs, apply clip marker and escape a colliding quotient
    always_comb begin
        q_x = i_data.neg_x ? DATA_W'(0) - i_data.quo_x : i_data.quo_x;
        q_y = i_data.neg_y ? DATA_W'(0) - i_data.quo_y : i_data.quo_y;
        n_item.screen_y     = q_y;
        n_item.screen_depth = i_data.depth_out;
        n_item.last_out     = i_data.last;
        if (i_data.clip) begin
            n_item.screen_x = CLIP_MARK_X;
        end else if (q_x == CLIP_MARK_X) begin
            n_item.screen_x = CLIP_ESCAPE_X;
        end else begin
            n_item.screen_x = q_x;
        end
    end

    assign o_advance = !r_skid_valid;
    assign arrive    = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_out_ready) begin
            if (arrive) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= arrive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_out_ready) begin
            if (arrive) begin
                r_skid <= n_item;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (arrive) begin
            r_out <= n_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### sv/vertex_perspective_divide_core.sv
// Perspective divide with near clipping, one vertex per transfer.
// Input channel (i_in_valid / o_in_ready / i_in_item): one vertex with depth,
// x and y numerators and a last flag. Output channel (o_out_valid /
// i_out_ready / o_out_item): screen x, y, depth and the copied last flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 near limit, 1 mid depth); other indexes are ignored.
// Write configuration only while no vertex is in flight.
// Path: an accepted vertex enters the first of 32 divider cells at the
// accepting edge, gains one quotient bit per cell, then lands in the
// output register. Throughput: one vertex per cycle unless a stall holds
// the chain; the rate is set by the cell chain, where every cell retires one
// restoring-division step for x and y together.
// Stall: when the receiver holds i_out_ready low, one more result drops into
// a skid register; o_in_ready then falls and the whole chain holds until
// the skid drains. o_in_ready never depends on i_out_ready in the same cycle.
// Reset (synchronous, active low): empties the chain and output stage, sets
// near limit to 50 and mid depth to 0.
module vertex_perspective_divide_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vpd_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  vpd_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output vpd_pkg::t_out_item                o_out_item
);
    import vpd_pkg::*;

    logic [DIV_W-1:0]  r_near_limit;
    logic [DATA_W-1:0] r_mid_depth;

    logic              advance;
    logic [DIV_W-1:0]  limit;
    logic              clip;
    t_cell_data        front;

    logic              cell_valid [NUM_CELLS+1];
    t_cell_data        cell_data  [NUM_CELLS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_limit <= NEAR_LIMIT_RST;
            r_mid_depth  <= MID_DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEAR_LIMIT: r_near_limit <= i_cfg_data[DIV_W-1:0];
                CFG_MID_DEPTH:  r_mid_depth  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: decide clipping and load magnitudes into the first cell.
    // A clipped vertex divides y by one so y passes through the chain intact.
    always_comb begin
        limit = (r_near_limit == '0) ? DIV_W'(1) : r_near_limit;
        clip  = $signed(i_in_item.depth) < $signed({1'b0, limit});
        front.clip      = clip;
        front.last      = i_in_item.last_in;
        // unclipped depth is positive, so the numerator sign is the result sign
        front.neg_x     = i_in_item.x_num[DATA_W-1];
        front.neg_y     = i_in_item.y_num[DATA_W-1];
        front.divisor   = clip ? DIV_W'(1) : i_in_item.depth[DIV_W-1:0];
        front.rem_x     = '0;
        front.rem_y     = '0;
        front.quo_x     = i_in_item.x_num[DATA_W-1] ? DATA_W'(0) - i_in_item.x_num
                                                    : i_in_item.x_num;
        front.quo_y     = i_in_item.y_num[DATA_W-1] ? DATA_W'(0) - i_in_item.y_num
                                                    : i_in_item.y_num;
        front.depth_out = i_in_item.depth - r_mid_depth;
    end

    assign o_in_ready    = advance;
    assign cell_valid[0] = i_in_valid;
    assign cell_data[0]  = front;

    // divider chain: each cell hands its partial result to the next
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        vpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_valid (cell_valid[g]),
            .i_data  (cell_data[g]),
            .o_valid (cell_valid[g+1]),
            .o_data  (cell_data[g+1])
        );
    end

    vpd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cell_valid[NUM_CELLS]),
        .i_data      (cell_data[NUM_CELLS]),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### tb/sv/vertex_divide_checker.sv
module vertex_divide_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vpd_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  vpd_pkg::t_in_item             i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  vpd_pkg::t_out_item            i_out_item,
    output int                            o_pending,
    output int                            o_mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import vpd_pkg::*;

    logic [DIV_W-1:0]  near_copy = NEAR_LIMIT_RST;
    logic [DATA_W-1:0] mid_copy  = MID_DEPTH_RST;
    t_out_item         expected_screen[$];
    int                pending_count = 0;
    int                mismatches    = 0;

    assign o_pending        = pending_count;
    assign o_mismatch_count = mismatches;

    // Screen position and depth of one vertex under the current registers.
    function automatic t_out_item predict_screen_vertex(t_in_item v,
                                                        logic [DIV_W-1:0] near,
                                                        logic [DATA_W-1:0] mid);
        t_out_item r;
        longint    floor_depth;
        longint    d;
        floor_depth    = (near == '0) ? 64'sd1 : longint'({1'b0, near});
        d              = longint'($signed(v.depth));
        r.screen_depth = v.depth - mid;
        r.last_out     = v.last_in;
        if (d < floor_depth) begin
            r.screen_x = CLIP_MARK_X;
            r.screen_y = v.y_num;
        end else begin
            r.screen_x = 32'(longint'($signed(v.x_num)) / d);
            r.screen_y = 32'(longint'($signed(v.y_num)) / d);
            if (r.screen_x == CLIP_MARK_X) begin
                r.screen_x = CLIP_ESCAPE_X;
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic signed [DATA_W-1:0] want,
                               logic signed [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            near_copy = NEAR_LIMIT_RST;
            mid_copy  = MID_DEPTH_RST;
            expected_screen.delete();
        end else begin
            // compare the outgoing transfer before queuing the incoming one
            if (i_out_valid && i_out_ready) begin
                if (expected_screen.size() == 0) begin
                    $display("%0t: unexpected result, got x %0d y %0d depth %0d last %0b",
                             $time, i_out_item.screen_x, i_out_item.screen_y,
                             i_out_item.screen_depth, i_out_item.last_out);
                    mismatches++;
                end else begin
                    want = expected_screen.pop_front();
                    check_field("screen_x", want.screen_x, i_out_item.screen_x);
                    check_field("screen_y", want.screen_y, i_out_item.screen_y);
                    check_field("screen_depth", want.screen_depth,
                                i_out_item.screen_depth);
                    check_field("last_out", 32'(want.last_out), 32'(i_out_item.last_out));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_screen.push_back(predict_screen_vertex(i_in_item, near_copy,
                                                                mid_copy));
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NEAR_LIMIT: near_copy = i_cfg_data[DIV_W-1:0];
                    CFG_MID_DEPTH:  mid_copy  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending_count = expected_screen.size();
    end

endmodule

### tb/sv/tb_vertex_perspective_divide_core.sv
module tb_vertex_perspective_divide_core;
    timeunit 1ns;
    timeprecision 1ps;
    import vpd_pkg::*;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;

    logic                 in_xfer   = 1'b0;
    int                   pending;
    int                   mismatch_total;

    // stimulus shaping only: the near limit now in force
    logic [DIV_W-1:0]     cur_near  = NEAR_LIMIT_RST;
    bit                   tx_steady = 1'b0;
    bit                   rx_steady = 1'b0;
    int                   stall_left = 0;

    vertex_perspective_divide_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    vertex_divide_checker u_screen_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_item        (in_item),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_item       (out_item),
        .o_pending        (pending),
        .o_mismatch_count (mismatch_total)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // Latch the input handshake at the rising edge; the sender reads it at
    // the following falling edge, so no race with the block's own update.
    always @(posedge clk) begin
        in_xfer <= in_valid && in_ready;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Receiver back-pressure: random stalls unless a steady stretch is on.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
            stall_left = gap_len() - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic t_in_item make_vertex(longint depth, longint x, longint y,
                                             bit last);
        t_in_item v;
        v.depth   = 32'(depth);
        v.x_num   = 32'(x);
        v.y_num   = 32'(y);
        v.last_in = last;
        return v;
    endfunction

    // Random vertex aimed at the interesting depths for the current near
    // limit: around the limit, small divisors, non-positive, the top of the
    // range, and numerators built so the x quotient lands on the clip marker.
    function automatic t_in_item random_vertex();
        t_in_item v;
        longint   lim;
        longint   d;
        int       mode;
        lim       = (cur_near == '0) ? 64'sd1 : longint'({1'b0, cur_near});
        v.depth   = $urandom;
        v.x_num   = $urandom;
        v.y_num   = $urandom;
        v.last_in = 1'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            v.x_num = 32'(longint'($urandom_range(0, 20000)) - 64'sd10000);
        end
        if ($urandom_range(0, 3) == 0) begin
            v.y_num = 32'(longint'($urandom_range(0, 20000)) - 64'sd10000);
        end
        mode = $urandom_range(0, 9);
        unique case (mode)
            0, 1: ;
            2, 3: begin
                d = lim + longint'($urandom_range(0, 4)) - 64'sd2;
                if (d > S32_MAX) begin
                    d = S32_MAX;
                end
                v.depth = 32'(d);
            end
            4, 5: v.depth = $urandom_range(1, 2000);
            6: begin
                if ($urandom_range(0, 7) == 0) begin
                    v.depth = 32'(S32_MIN);
                end else begin
                    v.depth = 32'(-longint'($urandom_range(0, 1000)));
                end
            end
            7, 8: begin
                d = longint'($urandom_range(1, 400));
                if (d < lim) begin
                    d = lim;
                end
                v.depth = 32'(d);
                // -5000*d minus less than d truncates to exactly -5000
                if (d <= 64'sd429496) begin
                    v.x_num = 32'(-64'sd5000 * d
                                  - longint'($urandom_range(0, int'(d) - 1)));
                end
            end
            default: v.depth = 32'(S32_MAX - longint'($urandom_range(0, 3)));
        endcase
        return v;
    endfunction

    // Present one vertex and hold it until the transfer; entered and left
    // at a falling edge. A gap lowers valid first; with no gap valid simply
    // stays high into the next vertex.
    task automatic send_vertex(t_in_item v);
        int gap;
        gap = (tx_steady || $urandom_range(0, 99) < 70) ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= v;
        do @(negedge clk); while (!in_xfer);
    endtask

    // Drop valid and hold until every queued result has come back. Always
    // waits for a falling edge so valid is never lowered and raised in
    // the same step.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_NEAR_LIMIT) begin
            cur_near = data[DIV_W-1:0];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Registers change only with the pipeline empty. The bit above the
    // near limit is random to show it is dropped.
    task automatic set_config(logic [DIV_W-1:0] near, logic [DATA_W-1:0] mid);
        wait_drained();
        write_reg(CFG_NEAR_LIMIT, {1'($urandom), near});
        write_reg(CFG_MID_DEPTH, mid);
    endtask

    task automatic run_random(int count, bit drain_midway);
        for (int i = 0; i < count; i++) begin
            if (drain_midway && i == count / 2) begin
                wait_drained();
            end
            send_vertex(random_vertex());
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed vertices under reset registers (near 50, mid 0).
        // Clipped: most negative, negative, zero, just below the limit.
        send_vertex(make_vertex(S32_MIN, S32_MIN, S32_MAX, 1'b0));
        send_vertex(make_vertex(-1, 5, -7, 1'b1));
        send_vertex(make_vertex(0, 123, 456, 1'b0));
        send_vertex(make_vertex(49, -5000, -1, 1'b1));
        // At and just past the limit.
        send_vertex(make_vertex(50, 1000, -2000, 1'b1));
        send_vertex(make_vertex(51, -1000, 1000, 1'b0));
        // Largest depth, then depth 1000, with extreme numerators.
        send_vertex(make_vertex(S32_MAX, S32_MAX, S32_MIN, 1'b0));
        send_vertex(make_vertex(S32_MAX, S32_MIN, S32_MAX, 1'b1));
        send_vertex(make_vertex(1000, S32_MIN, S32_MAX, 1'b0));
        // Quotient hitting the clip marker gets escaped; y is never escaped.
        send_vertex(make_vertex(50, -250000, 7, 1'b0));
        send_vertex(make_vertex(60, -300059, -300000, 1'b1));
        send_vertex(make_vertex(50, 250000, -250000, 1'b0));
        // Neighbors of the marker pass untouched.
        send_vertex(make_vertex(100, -499999, 0, 1'b0));
        send_vertex(make_vertex(50, -250050, 3, 1'b1));
        // Truncation toward zero on negative numerators.
        send_vertex(make_vertex(50, -7, 7, 1'b0));
        send_vertex(make_vertex(52, -103, 103, 1'b1));

        // Reset registers, random traffic, one full drain halfway through.
        run_random(90, 1'b1);

        // Near limit written as zero acts as one; mid at its minimum.
        set_config('0, 32'h8000_0000);
        send_vertex(make_vertex(1, -5000, S32_MAX, 1'b0));
        send_vertex(make_vertex(0, 77, -77, 1'b1));
        send_vertex(make_vertex(1, S32_MIN, S32_MAX, 1'b0));
        run_random(80, 1'b0);

        // Smallest legal near limit, mid at its maximum, no idling at all.
        set_config(31'd1, 32'h7FFF_FFFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_vertex(make_vertex(1, -5000, 5000, 1'b1));
        send_vertex(make_vertex(S32_MIN, 1, 1, 1'b0));
        run_random(80, 1'b0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Largest near limit: only the top depth survives.
        set_config(31'h7FFF_FFFF, 32'd12345);
        send_vertex(make_vertex(S32_MAX, S32_MIN, -5000, 1'b0));
        send_vertex(make_vertex(S32_MAX - 1, 42, -42, 1'b1));
        run_random(40, 1'b0);

        // Random registers; writes to spare indexes must change nothing.
        set_config(31'($urandom_range(2, 1000)), $urandom);
        write_reg(CFG_SPARE_2, $urandom);
        write_reg(CFG_SPARE_3, $urandom);
        run_random(100, 1'b0);

        // Steady sender against a stalling receiver.
        set_config(31'd1000, 32'hFFFF_FFFF);
        tx_steady = 1'b1;
        run_random(100, 1'b0);
        tx_steady = 1'b0;

        // Let everything drain, then keep clocking to catch strays.
        wait_drained();
        repeat (80) @(negedge clk);
        if (mismatch_total == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
